// File: sv/fca_pkg.sv
package fca_pkg;

	// fixed field widths
	localparam int unsigned MODE_W = 2;
	localparam int unsigned IDX_W  = 10;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned CNT_W  = 11;
	localparam int unsigned STAT_W = 2;

	localparam logic [VAL_W-1:0] END_MARK    = '1;
	localparam logic [CNT_W-1:0] LEN_MAX     = '1;
	localparam logic [CNT_W-1:0] BLOCKS_RST  = 11'd1024;

	// item modes
	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD  = 2'd0,
		MODE_ALLOC = 2'd1,
		MODE_CLOSE = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_SPACE = 2'd1,
		STAT_NO_CHAIN = 2'd2
	} status_t;

	// how an item finishes
	typedef enum logic [2:0] {
		FIN_LOAD  = 3'd0,
		FIN_READ  = 3'd1,
		FIN_CLOSE = 3'd2,
		FIN_ALLOC = 3'd3,
		FIN_FAIL  = 3'd4
	} fin_kind_t;

	// controller to datapath
	typedef struct packed {
		logic      clr_we;
		logic      take;
		logic      scan_init;
		logic      scan_run;
		logic      rd_issue;
		logic      fin;
		fin_kind_t fin_kind;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic  clear_done;
		logic  out_free;
		logic  scan_hit;
		logic  scan_miss;
		mode_t mode;
	} dp_stat_t;

endpackage

// File: sv/fca_ram.sv
module fca_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/fca_dpath.sv
module fca_dpath #(
	parameter int unsigned TABLE_ENTRIES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fca_pkg::dp_cmd_t           cmd,
	output fca_pkg::dp_stat_t          stat,
	input  logic [fca_pkg::MODE_W-1:0] in_mode,
	input  logic [fca_pkg::IDX_W-1:0]  in_idx,
	input  logic [fca_pkg::VAL_W-1:0]  in_val,
	input  logic                       cfg_valid,
	input  logic [fca_pkg::CNT_W-1:0]  cfg_data,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [fca_pkg::IDX_W-1:0]  out_blk,
	output logic [fca_pkg::STAT_W-1:0] out_stat,
	output logic [fca_pkg::CNT_W-1:0]  out_len,
	output logic [fca_pkg::VAL_W-1:0]  out_rd
);

	import fca_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_ENTRIES);
	localparam logic [16:0] TE_L = 17'(TABLE_ENTRIES);
	localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_ENTRIES - 1);

	// configuration and item registers
	logic [CNT_W-1:0] block_count_q;
	mode_t            mode_q;
	logic [IDX_W-1:0] idx_q;
	logic [VAL_W-1:0] val_q;

	// chain state
	logic             open_q;
	logic [CNT_W-1:0] last_q;
	logic [CNT_W-1:0] blocks_q;

	// scan state
	logic [CNT_W-1:0] scan_q;
	logic             pend_q;
	logic [CNT_W-1:0] pend_idx_q;
	logic [AW-1:0]    clr_q;

	// result register
	logic             out_valid_q;
	logic [IDX_W-1:0] out_blk_q;
	status_t          out_stat_q;
	logic [CNT_W-1:0] out_len_q;
	logic [VAL_W-1:0] out_rd_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [VAL_W-1:0] ram_rdata;

	logic [CNT_W-1:0] limit;
	logic             idx_ok;
	logic             last_ok;
	logic             hit;
	logic             below;
	logic             scan_issue;
	logic [CNT_W-1:0] blocks_inc;

	// scan bound is the smaller of block_count and the table size
	assign limit   = (17'(block_count_q) < TE_L) ? block_count_q : CNT_W'(TABLE_ENTRIES);
	assign idx_ok  = 17'(idx_q) < TE_L;
	assign last_ok = 17'(last_q) < TE_L;
	assign hit     = pend_q && (ram_rdata == '0);
	assign below   = scan_q < limit;
	assign scan_issue = cmd.scan_run && !hit && below;
	assign blocks_inc = (blocks_q < LEN_MAX) ? CNT_W'(blocks_q + 1'b1) : blocks_q;

	assign stat.clear_done = (clr_q == CLR_LAST);
	assign stat.out_free   = !out_valid_q || out_ready;
	assign stat.scan_hit   = hit;
	assign stat.scan_miss  = !hit && !below;
	assign stat.mode       = mode_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= BLOCKS_RST;
		end else if (cfg_valid) begin
			block_count_q <= cfg_data;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q <= mode_t'(in_mode);
			idx_q  <= in_idx;
			val_q  <= in_val;
		end
	end

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_q <= AW'(clr_q + 1'b1);
		end
	end

	// scan address and outstanding read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
		end else if (cmd.scan_init) begin
			scan_q <= open_q ? CNT_W'(last_q + 1'b1) : '0;
			pend_q <= 1'b0;
		end else if (scan_issue) begin
			scan_q     <= CNT_W'(scan_q + 1'b1);
			pend_q     <= 1'b1;
			pend_idx_q <= scan_q;
		end
	end

	// table write and read port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		if (cmd.fin) begin
			case (cmd.fin_kind)
				FIN_LOAD: begin
					ram_we    = idx_ok;
					ram_waddr = AW'(idx_q);
					ram_wdata = val_q;
				end
				FIN_CLOSE: begin
					ram_we    = open_q && last_ok;
					ram_waddr = AW'(last_q);
					ram_wdata = END_MARK;
				end
				FIN_ALLOC: begin
					ram_we    = open_q && last_ok;
					ram_waddr = AW'(last_q);
					ram_wdata = VAL_W'(pend_idx_q);
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end else if (cmd.clr_we) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re    = cmd.rd_issue || scan_issue;
	assign ram_raddr = cmd.rd_issue ? AW'(idx_q) : AW'(scan_q);

	fca_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// chain state update on finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			last_q   <= '0;
			blocks_q <= '0;
		end else if (cmd.fin) begin
			case (cmd.fin_kind)
				FIN_CLOSE: begin
					open_q   <= 1'b0;
					last_q   <= '0;
					blocks_q <= '0;
				end
				FIN_ALLOC: begin
					open_q   <= 1'b1;
					last_q   <= pend_idx_q;
					blocks_q <= blocks_inc;
				end
				default: begin
					open_q <= open_q;
				end
			endcase
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_blk_q  <= '0;
			out_stat_q <= STAT_OK;
			out_len_q  <= blocks_q;
			out_rd_q   <= '0;
			case (cmd.fin_kind)
				FIN_READ: begin
					out_rd_q <= idx_ok ? ram_rdata : '0;
				end
				FIN_CLOSE: begin
					if (open_q) begin
						out_blk_q <= last_q[IDX_W-1:0];
					end else begin
						out_stat_q <= STAT_NO_CHAIN;
					end
				end
				FIN_ALLOC: begin
					out_blk_q <= pend_idx_q[IDX_W-1:0];
					out_len_q <= blocks_inc;
				end
				FIN_FAIL: begin
					out_stat_q <= STAT_NO_SPACE;
				end
				default: begin
					out_rd_q <= '0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_blk   = out_blk_q;
	assign out_stat  = out_stat_q;
	assign out_len   = out_len_q;
	assign out_rd    = out_rd_q;

endmodule

// File: sv/fca_ctrl.sv
module fca_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fca_pkg::dp_stat_t  stat,
	output fca_pkg::dp_cmd_t   cmd
);

	import fca_pkg::*;

	typedef enum logic [6:0] {
		ST_CLEAR   = 7'b0000001,
		ST_IDLE    = 7'b0000010,
		ST_EXEC    = 7'b0000100,
		ST_RDWAIT  = 7'b0001000,
		ST_SCAN    = 7'b0010000,
		ST_ALLOC   = 7'b0100000,
		ST_FAIL    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.fin_kind = FIN_LOAD;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (stat.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (stat.mode)
					MODE_LOAD: begin
						cmd.fin_kind = FIN_LOAD;
						if (stat.out_free) begin
							cmd.fin = 1'b1;
							state_d = ST_IDLE;
						end
					end
					MODE_CLOSE: begin
						cmd.fin_kind = FIN_CLOSE;
						if (stat.out_free) begin
							cmd.fin = 1'b1;
							state_d = ST_IDLE;
						end
					end
					MODE_READ: begin
						cmd.rd_issue = 1'b1;
						state_d      = ST_RDWAIT;
					end
					MODE_ALLOC: begin
						cmd.scan_init = 1'b1;
						state_d       = ST_SCAN;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_RDWAIT: begin
				cmd.fin_kind = FIN_READ;
				if (stat.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_hit) begin
					state_d = ST_ALLOC;
				end else if (stat.scan_miss) begin
					state_d = ST_FAIL;
				end
			end
			ST_ALLOC: begin
				cmd.fin_kind = FIN_ALLOC;
				if (stat.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_FAIL: begin
				cmd.fin_kind = FIN_FAIL;
				if (stat.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: sv/fat_chain_allocator_core.sv
// channel  | handshake            | payload (lowest bit first)
// s_       | s_tvalid / s_tready  | tuser: mode; tdata: entry_index, entry_value
// m_       | m_tvalid / m_tready  | tuser: status; tdata: block_index, chain_length, read_value
// cfg_     | cfg_valid / cfg_ready| cfg_data: block_count
//
// one item at a time: load and close finish in the execute state, read after the table read port returns its data
// allocate scans the table entries one per cycle, from the scan start up to the free entry
// or the scan bound, the smaller of block_count and TABLE_ENTRIES
// after reset a clearing pass writes every table entry to zero,
// with s_tready low; cfg writes are taken at any time
// a result waiting on m_tready does not block the next transfer in, only its finish
module fat_chain_allocator_core #(
	parameter int unsigned TABLE_ENTRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // entry_index[9:0], entry_value[41:10], zero pad
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // block_index[9:0], chain_length[20:10], read_value[52:21]
	output logic [1:0]  m_tuser,   // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data   // block_count[10:0]
);

	import fca_pkg::*;

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [IDX_W-1:0] out_blk;
	logic [CNT_W-1:0] out_len;
	logic [VAL_W-1:0] out_rd;

	assign cfg_ready = 1'b1;

	fca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fca_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_mode   (s_tuser),
		.in_idx    (s_tdata[IDX_W-1:0]),
		.in_val    (s_tdata[IDX_W+VAL_W-1:IDX_W]),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_blk   (out_blk),
		.out_stat  (m_tuser),
		.out_len   (out_len),
		.out_rd    (out_rd)
	);

	// result packing
	assign m_tdata = {3'b000, out_rd, out_len, out_blk};

endmodule

// File: sv/fca_checker.sv
module fca_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [1:0]  m_tuser
);

	import fca_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// only defined status codes appear
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_NO_SPACE
			|| m_tuser == STAT_NO_CHAIN))
		else $error("undefined status code");

	// a failed item reports no block and no read data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_NO_SPACE || m_tuser == STAT_NO_CHAIN)
		|-> m_tdata[9:0] == '0 && m_tdata[52:21] == '0)
		else $error("failure result carries data");

	// closing with no open chain shows an empty chain
	a_no_chain_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_NO_CHAIN |-> m_tdata[20:10] == '0)
		else $error("no chain but nonzero length");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transfer taken while busy");

endmodule

bind fat_chain_allocator_core fca_checker u_fca_checker (.*);
